// File: design/dll_pkg.sv
// Package for the cursor linked list: default sizes, command and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none
package dll_pkg;

  localparam int DEF_POOL_NODES = 256;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OPCODE_W = 4;
  localparam int ITEM_W   = 32;
  localparam int MOVE_W   = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam logic [OPCODE_W-1:0] OP_INS_BEFORE = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_AFTER  = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_APPEND     = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_DELETE     = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_READ       = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_MOVE       = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_FIRST      = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS1,
    S_INS2,
    S_DEL1,
    S_MV0,
    S_MV1,
    S_SR0,
    S_SR1,
    S_RD,
    S_RSP
  } state_t;

endpackage
`default_nettype wire

// File: design/dll_cmd_if.sv
// Command channel: valid/ready handshake with opcode, value and move count.
// Depends on dll_pkg.
`default_nettype none
interface dll_cmd_if import dll_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ITEM_W-1:0]          item_value;
  logic signed [MOVE_W-1:0]   move_count;

  modport source (output valid, output opcode, output item_value, output move_count,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input move_count,
                  output ready);
endinterface
`default_nettype wire

// File: design/dll_rsp_if.sv
// Result channel: valid/ready handshake with status, cursor value and count.
// Depends on dll_pkg.
`default_nettype none
interface dll_rsp_if import dll_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ITEM_W-1:0]    current_value;
  logic [COUNT_W-1:0]   element_count;
  logic                 list_empty;

  modport source (output valid, output status, output current_value,
                  output element_count, output list_empty, input ready);
  modport sink   (input valid, input status, input current_value,
                  input element_count, input list_empty, output ready);
endinterface
`default_nettype wire

// File: design/dll_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// Depends on dll_pkg for default sizes.
`default_nettype none
module dll_ram import dll_pkg::*; #(
  parameter int DEPTH = DEF_POOL_NODES,
  parameter int WIDTH = DEF_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/cursor_doubly_linked_list.sv
// Cursor doubly linked list over a fixed pool of POOL_NODES nodes. One command
// transaction in, one result transaction out; the block takes one command at a
// time and cmd.ready is high only while the sequencer is idle. Every command
// ends with a registered read of the cursor's value. Inserts pass S_INS1 and,
// into a non-empty list, S_INS2; delete passes S_DEL1. Move loops S_MV0/S_MV1
// once per hop taken (hops stop early at either end; a zero count runs as a
// read), and search loops S_SR0/S_SR1 once per node visited, because each
// link hop is one read of the link RAM with a registered output. The result
// sits in an output register, so the next command can be taken while it waits.
// Node values and links live in RAMs that are never cleared: links are always
// written when a node is allocated. The free-node stack is a RAM plus a
// low-water mark; stack slots below the mark still hold their reset contents
// implicitly, so clear and reset take effect at once with no sweep.
`default_nettype none
module cursor_doubly_linked_list import dll_pkg::*; #(
  parameter int POOL_NODES = DEF_POOL_NODES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input wire logic   clk,
  input wire logic   rst,
  dll_cmd_if.sink    cmd,
  dll_rsp_if.source  rsp
);
  localparam int NW = $clog2(POOL_NODES + 1);  // node index incl. null
  localparam int AW = $clog2(POOL_NODES);      // RAM address
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  state_t state, state_next;

  // list registers
  logic [NW-1:0] head, head_next, tail, tail_next, cursor, cursor_next;
  logic [NW-1:0] count, count_next, free_top, free_top_next, free_low, free_low_next;
  // command registers
  logic [OPCODE_W-1:0]   op_r, op_r_next;
  logic [VALUE_BITS-1:0] val_r, val_r_next;
  logic [MOVE_W-1:0]     rem, rem_next;
  logic                  fwd, fwd_next;
  logic [NW-1:0]         e, e_next, n_r, n_r_next, nb_r, nb_r_next;
  logic [STATUS_W-1:0]   st_r, st_r_next;
  // output register
  logic                ov;
  logic [STATUS_W-1:0] o_status;
  logic [ITEM_W-1:0]   o_value;
  logic [COUNT_W-1:0]  o_count;
  logic                o_empty;
  logic                load;

  // RAM ports
  logic                  val_we, nxt_we, prv_we, frs_we;
  logic [AW-1:0]         val_wa, nxt_wa, prv_wa, frs_wa;
  logic [AW-1:0]         val_ra, nxt_ra, prv_ra, frs_ra;
  logic [VALUE_BITS-1:0] val_wd, val_rd;
  logic [NW-1:0]         nxt_wd, nxt_rd, prv_wd, prv_rd;
  logic [AW-1:0]         frs_wd, frs_rd;

  logic                  accept, empty, after, k_zero;
  logic [NW-1:0]         eff_c, ft_dec, new_node;
  logic [63:0]           in_ext, rd_ext, cnt_ext;
  logic [VALUE_BITS-1:0] in_val;

  dll_ram #(.DEPTH(POOL_NODES), .WIDTH(VALUE_BITS)) u_val (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));
  dll_ram #(.DEPTH(POOL_NODES), .WIDTH(NW)) u_next (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
  dll_ram #(.DEPTH(POOL_NODES), .WIDTH(NW)) u_prev (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd));
  dll_ram #(.DEPTH(POOL_NODES), .WIDTH(AW)) u_free (
    .clk, .we(frs_we), .waddr(frs_wa), .wdata(frs_wd), .raddr(frs_ra), .rdata(frs_rd));

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign empty  = (cursor >= NIL);
  assign after  = (op_r != OP_INS_BEFORE);
  assign k_zero = (cmd.move_count == '0);
  assign eff_c  = (cmd.opcode == OP_APPEND) ? tail : cursor;
  assign ft_dec = free_top - NW'(1);
  assign in_ext = {32'b0, cmd.item_value};
  assign in_val = in_ext[VALUE_BITS-1:0];
  assign rd_ext = 64'(val_rd);
  assign cnt_ext = 64'(count);
  // stack slot below the low-water mark still holds its reset index
  assign new_node = (free_top < free_low) ? (NIL - NW'(1) - free_top) : NW'(frs_rd);
  assign load = (state == S_RSP) && (!ov || rsp.ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RD;
          case (cmd.opcode) inside
            OP_INS_BEFORE, OP_INS_AFTER, OP_APPEND:
              if (free_top != '0) state_next = S_INS1;
            OP_DELETE: if (!empty) state_next = S_DEL1;
            OP_MOVE:   if (!empty && !k_zero) state_next = S_MV0;
            OP_SEARCH: if (!empty) state_next = S_SR0;
            default: state_next = S_RD;
          endcase
        end
      end
      S_INS1: state_next = (cursor < NIL) ? S_INS2 : S_RD;
      S_INS2: state_next = S_RD;
      S_DEL1: state_next = S_RD;
      S_MV0:  state_next = (rem != '0 && e < NIL) ? S_MV1 : S_RD;
      S_MV1:  state_next = S_MV0;
      S_SR0:  state_next = (e < NIL) ? S_SR1 : S_RD;
      S_SR1:  state_next = (val_rd == val_r) ? S_RD : S_SR0;
      S_RD:   state_next = S_RSP;
      S_RSP:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    head_next = head; tail_next = tail; cursor_next = cursor; count_next = count;
    free_top_next = free_top; free_low_next = free_low;
    op_r_next = op_r; val_r_next = val_r; rem_next = rem; fwd_next = fwd;
    e_next = e; n_r_next = n_r; nb_r_next = nb_r; st_r_next = st_r;
    val_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; frs_we = 1'b0;
    val_wa = n_r[AW-1:0]; val_wd = val_r;
    nxt_wa = n_r[AW-1:0]; nxt_wd = NIL;
    prv_wa = n_r[AW-1:0]; prv_wd = NIL;
    frs_wa = free_top[AW-1:0]; frs_wd = cursor[AW-1:0];
    val_ra = cursor[AW-1:0]; nxt_ra = cursor[AW-1:0]; prv_ra = cursor[AW-1:0];
    frs_ra = ft_dec[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next  = cmd.opcode;
          val_r_next = in_val;
          st_r_next  = empty ? ST_EMPTY : ST_OK;
          case (cmd.opcode) inside
            OP_INS_BEFORE, OP_INS_AFTER, OP_APPEND: begin
              cursor_next = eff_c;
              nxt_ra = eff_c[AW-1:0];
              prv_ra = eff_c[AW-1:0];
              if (free_top == '0) begin
                st_r_next = ST_NO_MEM;
              end else begin
                st_r_next = ST_OK;
                free_top_next = ft_dec;
              end
            end
            OP_MOVE: begin
              e_next   = cursor;
              fwd_next = !cmd.move_count[MOVE_W-1];
              rem_next = cmd.move_count[MOVE_W-1] ? MOVE_W'(-cmd.move_count)
                                                  : MOVE_W'(cmd.move_count);
            end
            OP_SEARCH: e_next = cursor;
            OP_FIRST: begin
              cursor_next = head;
              st_r_next = (head < NIL) ? ST_OK : ST_EMPTY;
            end
            OP_CLEAR: begin
              head_next = NIL; tail_next = NIL; cursor_next = NIL; count_next = '0;
              free_top_next = NIL; free_low_next = NIL;
              st_r_next = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_INS1: begin
        n_r_next = new_node;
        val_we = 1'b1; val_wa = new_node[AW-1:0];
        nxt_we = 1'b1; nxt_wa = new_node[AW-1:0];
        prv_we = 1'b1; prv_wa = new_node[AW-1:0];
        if (cursor >= NIL) begin
          head_next = new_node; tail_next = new_node;
          cursor_next = new_node;
          count_next = count + NW'(1);
        end else if (after) begin
          nb_r_next = nxt_rd;
          nxt_wd = nxt_rd; prv_wd = cursor;
          if (nxt_rd >= NIL) tail_next = new_node;
        end else begin
          nb_r_next = prv_rd;
          prv_wd = prv_rd; nxt_wd = cursor;
          if (prv_rd >= NIL) head_next = new_node;
        end
      end
      S_INS2: begin
        if (after) begin
          nxt_we = 1'b1; nxt_wa = cursor[AW-1:0]; nxt_wd = n_r;
          prv_we = (nb_r < NIL); prv_wa = nb_r[AW-1:0]; prv_wd = n_r;
        end else begin
          prv_we = 1'b1; prv_wa = cursor[AW-1:0]; prv_wd = n_r;
          nxt_we = (nb_r < NIL); nxt_wa = nb_r[AW-1:0]; nxt_wd = n_r;
        end
        cursor_next = n_r;
        count_next = count + NW'(1);
      end
      S_DEL1: begin
        // prv_rd is the predecessor, nxt_rd the successor
        if (prv_rd < NIL) begin
          nxt_we = 1'b1; nxt_wa = prv_rd[AW-1:0]; nxt_wd = nxt_rd;
          cursor_next = prv_rd;
        end else begin
          cursor_next = nxt_rd;
          head_next = nxt_rd;
        end
        if (nxt_rd < NIL) begin
          prv_we = 1'b1; prv_wa = nxt_rd[AW-1:0]; prv_wd = prv_rd;
        end else begin
          tail_next = prv_rd;
        end
        if (free_top < NIL) begin
          frs_we = 1'b1;
          free_top_next = free_top + NW'(1);
          if (free_top < free_low) free_low_next = free_top;
        end
        if (count != '0) count_next = count - NW'(1);
        st_r_next = ST_OK;
      end
      S_MV0: begin
        nxt_ra = e[AW-1:0];
        prv_ra = e[AW-1:0];
        if (!(rem != '0 && e < NIL)) begin
          if (e < NIL) begin
            cursor_next = e; st_r_next = ST_OK;
          end else begin
            cursor_next = fwd ? tail : head; st_r_next = ST_END;
          end
        end
      end
      S_MV1: begin
        e_next = fwd ? nxt_rd : prv_rd;
        rem_next = rem - MOVE_W'(1);
      end
      S_SR0: begin
        val_ra = e[AW-1:0];
        nxt_ra = e[AW-1:0];
        if (e >= NIL) st_r_next = ST_NOT_FOUND;
      end
      S_SR1: begin
        if (val_rd == val_r) begin
          cursor_next = e; st_r_next = ST_OK;
        end else begin
          e_next = nxt_rd;
        end
      end
      S_RD, S_RSP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= NIL; tail <= NIL; cursor <= NIL; count <= '0;
      free_top <= NIL; free_low <= NIL;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next; tail <= tail_next; cursor <= cursor_next; count <= count_next;
      free_top <= free_top_next; free_low <= free_low_next;
      if (load) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_r_next; val_r <= val_r_next; rem <= rem_next; fwd <= fwd_next;
    e <= e_next; n_r <= n_r_next; nb_r <= nb_r_next; st_r <= st_r_next;
    if (load) begin
      o_status <= st_r;
      o_value  <= (cursor < NIL) ? rd_ext[ITEM_W-1:0] : '0;
      o_count  <= cnt_ext[COUNT_W-1:0];
      o_empty  <= (count == '0);
    end
  end

  assign rsp.valid         = ov;
  assign rsp.status        = o_status;
  assign rsp.current_value = o_value;
  assign rsp.element_count = o_count;
  assign rsp.list_empty    = o_empty;

  // empty count and null head go together between transactions
  ap_empty_head: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((count == '0) == (head >= NIL)))
    else $error("count and head disagree");

  // every node is either in the list or on the free stack
  ap_pool_sum: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (32'(count) + 32'(free_top) == 32'(POOL_NODES)))
    else $error("node pool leaked");

  // one command at a time
  ap_one_cmd: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("command taken while busy");
endmodule
`default_nettype wire

// File: tb/sv/dll_tb_pkg.sv
// Shared definitions for the cursor linked list testbench.
// Depends on dll_pkg.
package dll_tb_pkg;
  import dll_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [ITEM_W-1:0]        item_value;
    logic signed [MOVE_W-1:0] move_count;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   current_value;
    logic [COUNT_W-1:0]  element_count;
    logic                list_empty;
  } list_rsp_t;
endpackage

// File: tb/sv/dll_tb_if.sv
// Holder interfaces are taken from the design (dll_cmd_if, dll_rsp_if).
// This file adds a small idle-control interface shared by the driver processes.
// Depends on nothing.
interface dll_tb_ctrl_if ();
  logic no_idle;
  logic hold_off;
endinterface

// File: tb/sv/cursor_doubly_linked_list_test.sv
// Testbench for cursor_doubly_linked_list: a directed table then random command
// traffic, each result checked against an in-bench list predictor or typed row.
// Depends on dll_pkg, dll_tb_pkg, dll_cmd_if, dll_rsp_if, dll_tb_ctrl_if.
module cursor_doubly_linked_list_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dll_pkg::*;
  import dll_tb_pkg::*;

  localparam int NODES = DEF_POOL_NODES;
  localparam int NIL   = NODES;
  localparam int RANDOM_ITEMS = 1420;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dll_cmd_if     cmd ();
  dll_rsp_if     rsp ();
  dll_tb_ctrl_if ctl ();

  cursor_doubly_linked_list dut (.clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- predictor state: a shadow of the node pool ----
  logic [31:0] shadow_val  [NODES];
  int          shadow_next [NODES];
  int          shadow_prev [NODES];
  int          spare_stack [NODES];
  int          spare_top, head_at, tail_at, cur_at, live_nodes;

  list_rsp_t expected_rsps[$];
  int        mismatches = 0;

  function automatic void pool_reset();
    for (int i = 0; i < NODES; i++) spare_stack[i] = NIL - 1 - i;
    spare_top = NIL;
    head_at = NIL; tail_at = NIL; cur_at = NIL; live_nodes = 0;
  endfunction

  function automatic logic [STATUS_W-1:0] link_in(logic [31:0] v, bit after);
    int n, nb;
    if (spare_top == 0) return ST_NO_MEM;
    spare_top--;
    n = spare_stack[spare_top];
    shadow_val[n] = v; shadow_next[n] = NIL; shadow_prev[n] = NIL;
    live_nodes++;
    if (cur_at == NIL) begin
      head_at = n; tail_at = n;
    end else if (after) begin
      nb = shadow_next[cur_at];
      if (nb != NIL) begin
        shadow_next[n] = nb; shadow_prev[nb] = n;
      end else begin
        tail_at = n;
      end
      shadow_prev[n] = cur_at; shadow_next[cur_at] = n;
    end else begin
      nb = shadow_prev[cur_at];
      if (nb != NIL) begin
        shadow_prev[n] = nb; shadow_next[nb] = n;
      end else begin
        head_at = n;
      end
      shadow_next[n] = cur_at; shadow_prev[cur_at] = n;
    end
    cur_at = n;
    return ST_OK;
  endfunction

  function automatic void unlink_cursor();
    int c, p, q;
    c = cur_at; p = shadow_prev[c]; q = shadow_next[c];
    if (p != NIL) begin
      shadow_next[p] = q; cur_at = p;
    end else begin
      cur_at = q; head_at = q;
    end
    if (q != NIL) shadow_prev[q] = p;
    else tail_at = p;
    spare_stack[spare_top++] = c;
    live_nodes--;
  endfunction

  function automatic logic [STATUS_W-1:0] step_cursor(logic signed [MOVE_W-1:0] mc);
    int k, e;
    k = mc; e = cur_at;
    if (k > 0) begin
      while (k > 0 && e != NIL) begin e = shadow_next[e]; k--; end
      if (e != NIL) begin cur_at = e; return ST_OK; end
      cur_at = tail_at; return ST_END;
    end
    if (k < 0) begin
      while (k < 0 && e != NIL) begin e = shadow_prev[e]; k++; end
      if (e != NIL) begin cur_at = e; return ST_OK; end
      cur_at = head_at; return ST_END;
    end
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] seek_value(logic [31:0] v);
    int e;
    e = cur_at;
    while (e != NIL) begin
      if (shadow_val[e] == v) begin cur_at = e; return ST_OK; end
      e = shadow_next[e];
    end
    return ST_NOT_FOUND;
  endfunction

  // Applies one command to the shadow list and returns the result it causes.
  function automatic list_rsp_t list_apply(list_cmd_t c);
    list_rsp_t r;
    bit empty;
    empty = (cur_at == NIL);
    r.status = empty ? ST_EMPTY : ST_OK;
    case (c.opcode)
      OP_INS_BEFORE: r.status = link_in(c.item_value, 1'b0);
      OP_INS_AFTER:  r.status = link_in(c.item_value, 1'b1);
      OP_APPEND: begin
        cur_at = tail_at;
        r.status = link_in(c.item_value, 1'b1);
      end
      OP_DELETE: if (!empty) begin unlink_cursor(); r.status = ST_OK; end
      OP_MOVE:   if (!empty) r.status = step_cursor(c.move_count);
      OP_SEARCH: if (!empty) r.status = seek_value(c.item_value);
      OP_FIRST: begin
        cur_at = head_at;
        r.status = (head_at != NIL) ? ST_OK : ST_EMPTY;
      end
      OP_CLEAR: begin pool_reset(); r.status = ST_OK; end
      default: ;
    endcase
    r.current_value = (cur_at != NIL) ? shadow_val[cur_at] : '0;
    r.element_count = live_nodes[COUNT_W-1:0];
    r.list_empty    = (live_nodes == 0);
    return r;
  endfunction

  // ---- directed table: opcode, value, count; check flag + typed result ----
  typedef struct {
    list_cmd_t c;
    bit        typed;
    list_rsp_t r;
  } table_row_t;

  table_row_t stim_table[$];
  list_cmd_t  send_q[$];
  bit         typed_q[$];
  list_rsp_t  typed_rsp_q[$];

  function automatic list_cmd_t mk(logic [3:0] op, logic [31:0] v, int mc);
    list_cmd_t c;
    c.opcode = op; c.item_value = v; c.move_count = mc[MOVE_W-1:0];
    return c;
  endfunction

  function automatic list_rsp_t rs(logic [2:0] st, logic [31:0] v, int n);
    list_rsp_t r;
    r.status = st; r.current_value = v; r.element_count = n[COUNT_W-1:0];
    r.list_empty = (n == 0);
    return r;
  endfunction

  function automatic void row(list_cmd_t c, bit typed = 0, list_rsp_t r = '0);
    table_row_t t;
    t.c = c; t.typed = typed; t.r = r;
    stim_table.push_back(t);
  endfunction

  // Random command with a biased mix; small move counts mostly, extremes now and then.
  function automatic list_cmd_t random_cmd(int fill_bias);
    int pick, mc;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
    mc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 512) - 256
                                     : $urandom_range(0, 16) - 8;
    if (pick < 2)                 return mk(4'($urandom_range(9, 15)), $urandom, $urandom);
    if (pick < 3)                 return mk(OP_CLEAR, v, mc);
    if (pick < 10 + fill_bias)    return mk(OP_APPEND, v, mc);
    if (pick < 25 + fill_bias)    return mk(OP_INS_BEFORE, v, mc);
    if (pick < 40 + fill_bias)    return mk(OP_INS_AFTER, v, mc);
    if (pick < 55)                return mk(OP_DELETE, v, mc);
    if (pick < 63)                return mk(OP_READ, v, mc);
    if (pick < 80)                return mk(OP_MOVE, v, mc);
    if (pick < 93)                return mk(OP_SEARCH, v, mc);
    return mk(OP_FIRST, v, mc);
  endfunction

  initial begin
    pool_reset();

    // Empty-list behaviour, typed in from the spec.
    row(mk(OP_READ, 0, 0),               1, rs(ST_EMPTY, 0, 0));
    row(mk(OP_DELETE, 0, 0),             1, rs(ST_EMPTY, 0, 0));
    row(mk(OP_MOVE, 0, 5),               1, rs(ST_EMPTY, 0, 0));
    row(mk(OP_SEARCH, 7, 0),             1, rs(ST_EMPTY, 0, 0));
    row(mk(OP_FIRST, 0, 0),              1, rs(ST_EMPTY, 0, 0));
    row(mk(4'd15, 32'hFFFF_FFFF, -1),    1, rs(ST_EMPTY, 0, 0));
    // First node into an empty list.
    row(mk(OP_INS_BEFORE, 32'hFFFF_FFFF, 0), 1, rs(ST_OK, 32'hFFFF_FFFF, 1));
    row(mk(OP_INS_AFTER, 32'h0, 0),      1, rs(ST_OK, 0, 2));
    row(mk(OP_APPEND, 32'h5555_AAAA, 0), 1, rs(ST_OK, 32'h5555_AAAA, 3));
    row(mk(OP_MOVE, 0, 256),             1, rs(ST_END, 32'h5555_AAAA, 3));
    row(mk(OP_MOVE, 0, -256),            1, rs(ST_END, 32'hFFFF_FFFF, 3));
    row(mk(OP_MOVE, 0, 0),               1, rs(ST_OK, 32'hFFFF_FFFF, 3));
    row(mk(OP_MOVE, 0, 2));
    row(mk(OP_MOVE, 0, -1));
    row(mk(OP_SEARCH, 32'h5555_AAAA, 0));
    row(mk(OP_SEARCH, 32'h1234_5678, 0), 1, rs(ST_NOT_FOUND, 32'h5555_AAAA, 3));
    row(mk(OP_FIRST, 0, 0),              1, rs(ST_OK, 32'hFFFF_FFFF, 3));
    row(mk(OP_DELETE, 0, 0));
    row(mk(OP_INS_BEFORE, 32'hAAAA_5555, 0));
    row(mk(4'd9, 0, 0));
    row(mk(OP_CLEAR, 0, 0),              1, rs(ST_OK, 0, 0));
    // Fill the pool then overflow it.
    for (int i = 0; i < NODES; i++) row(mk(OP_APPEND, i, 0));
    row(mk(OP_INS_BEFORE, 32'hDEAD_BEEF, 0), 1, rs(ST_NO_MEM, NODES - 1, NODES));
    row(mk(OP_FIRST, 0, 0));
    row(mk(OP_APPEND, 32'hDEAD_BEEF, 0), 1, rs(ST_NO_MEM, NODES - 1, NODES));
    row(mk(OP_CLEAR, 0, 0),              1, rs(ST_OK, 0, 0));

    foreach (stim_table[i]) begin
      send_q.push_back(stim_table[i].c);
      typed_q.push_back(stim_table[i].typed);
      typed_rsp_q.push_back(stim_table[i].r);
    end
    // Random part; items 601 to 1099 lean towards inserts so the pool fills.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_q.push_back(random_cmd((i > 600 && i < 1100) ? 12 : 0));
      typed_q.push_back(1'b0);
      typed_rsp_q.push_back('0);
    end
  end

  // ---- command driver ----
  int  sent_items;
  bit  sent_all;
  initial begin
    cmd.valid = 1'b0; cmd.opcode = '0; cmd.item_value = '0; cmd.move_count = '0;
    sent_items = 0; sent_all = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (sent_items < send_q.size()) begin
      if (ctl.no_idle || $urandom_range(0, 99) >= 32) begin
        cmd.valid      <= 1'b1;
        cmd.opcode     <= send_q[sent_items].opcode;
        cmd.item_value <= send_q[sent_items].item_value;
        cmd.move_count <= send_q[sent_items].move_count;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        // Accepted here: predict now, in command order.
        begin
          list_rsp_t r;
          r = list_apply(send_q[sent_items]);
          if (typed_q[sent_items] && r !== typed_rsp_q[sent_items])
            r = typed_rsp_q[sent_items]; // typed row wins; the check then flags it
          expected_rsps.push_back(r);
        end
        sent_items++;
        if (sent_items < send_q.size() && (ctl.no_idle || $urandom_range(0, 99) >= 32))
          continue;
        cmd.valid <= 1'b0;
      end else begin
        cmd.valid <= 1'b0;
      end
      @(posedge clk);
    end
    cmd.valid <= 1'b0;
    sent_all = 1'b1;
  end

  // Phases of idling: a stretch with no idling, and one long hold-off of the receiver.
  initial begin
    int hold_cycles;
    ctl.no_idle  = 1'b0;
    ctl.hold_off = 1'b0;
    wait (sent_items > 400);
    ctl.no_idle = 1'b1;
    wait (sent_items > 700);
    ctl.no_idle = 1'b0;
    wait (sent_items > 900);
    ctl.hold_off = 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 300) begin
      @(posedge clk);
      hold_cycles++;
    end
    ctl.hold_off = 1'b0;
  end

  // ---- result sink and checker ----
  initial begin
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        list_rsp_t got;
        got.status = rsp.status; got.current_value = rsp.current_value;
        got.element_count = rsp.element_count; got.list_empty = rsp.list_empty;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          list_rsp_t want;
          want = expected_rsps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      rsp.ready <= !ctl.hold_off && (ctl.no_idle || $urandom_range(0, 99) >= 32);
    end
  end

  // ---- end of run ----
  initial begin
    wait (sent_all);
    wait (expected_rsps.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
